FILE: sv/mrul_pkg.sv
// ----------------------------------------------------------------------------
// mrul_pkg
// Shared sizes, word types, command codes and controller types for the
// most-recently-used key list.
// ----------------------------------------------------------------------------
package mrul_pkg;

	localparam int DEPTH     = 32;
	localparam int KEY_WIDTH = 32;

	// fixed port field widths
	localparam int CMD_W      = 3;
	localparam int KEY_IN_W   = 32;
	localparam int INDEX_IN_W = 5;
	localparam int COUNT_O_W  = 6;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CUR_W = CNT_W + 1;
	localparam int RD_W  = (CNT_W > INDEX_IN_W) ? CNT_W : INDEX_IN_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 3'd0,
		CMD_READ  = 3'd1,
		CMD_NEXT  = 3'd2,
		CMD_PREV  = 3'd3,
		CMD_RESET = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]      cmd;
		logic [KEY_IN_W-1:0]   key;
		logic [INDEX_IN_W-1:0] index;
	} req_t;

	typedef struct packed {
		logic [KEY_IN_W-1:0]  entry_key;
		logic                 entry_valid;
		logic                 was_hit;
		logic [COUNT_O_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctl_t;

endpackage

FILE: sv/mrul_ctrl.sv
// ----------------------------------------------------------------------------
// mrul_ctrl
// Command sequencer: takes a word into the datapath, then runs it once the
// result register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mrul_ctrl import mrul_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		ctl.capture = 1'b0;
		ctl.execute = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall   = 1'b0;
				ctl.capture = req_valid;
			end
			ST_EXEC: begin
				ctl.execute = out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.execute) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/mrul_dp.sv
// ----------------------------------------------------------------------------
// mrul_dp
// Row of key cells with parallel compare and shift-to-front, count and
// browse cursor registers, index read mux and the result register.
// ----------------------------------------------------------------------------
module mrul_dp import mrul_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	input  req_t req,
	output rsp_t rsp
);

	logic [KEY_WIDTH-1:0]    cell_q [DEPTH];
	logic [CNT_W-1:0]        count_q, count_d;
	logic signed [CUR_W-1:0] cursor_q, cursor_d;

	logic [CMD_W-1:0]     cmd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [RD_W-1:0]      index_q;
	logic [DEPTH-1:0]     shift_q;
	logic                 hit_q;
	rsp_t                 rsp_q, rsp_d;

	logic [KEY_WIDTH-1:0]    key_in;
	logic [DEPTH-1:0]        match, shift_d;
	logic signed [CUR_W-1:0] cnt_s, cur_inc, cur_dec;
	logic                    rd_ok, cur_ok;
	logic [IDX_W-1:0]        rd_addr;
	logic [KEY_WIDTH-1:0]    rd_key;

	// search at capture time
	assign key_in = KEY_WIDTH'(req.key);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (cell_q[i] == key_in);
		end
		for (int i = 0; i < DEPTH; i++) begin
			shift_d[i] = ~|(match & ((DEPTH'(1) << i) - DEPTH'(1)));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= req.cmd;
			key_q   <= key_in;
			index_q <= RD_W'(req.index);
			shift_q <= shift_d;
			hit_q   <= |match;
		end
	end

	// read side
	assign cnt_s   = signed'({1'b0, count_q});
	assign cur_inc = cursor_q + CUR_W'(1);
	assign cur_dec = cursor_q - CUR_W'(1);
	assign rd_ok   = index_q < RD_W'(count_q);
	assign cur_ok  = (cursor_q >= 0) && (cursor_q < cnt_s);
	assign rd_addr = (cmd_q == CMD_READ) ? IDX_W'(index_q) : IDX_W'(cursor_q);
	assign rd_key  = cell_q[rd_addr];

	always_comb begin
		count_d  = count_q;
		cursor_d = cursor_q;
		rsp_d    = '0;
		case (cmd_q)
			CMD_ADD: begin
				rsp_d.was_hit = hit_q;
				if (!hit_q && (count_q < CNT_W'(DEPTH))) count_d = count_q + CNT_W'(1);
			end
			CMD_READ: begin
				if (rd_ok) begin
					rsp_d.entry_valid = 1'b1;
					rsp_d.entry_key   = KEY_IN_W'(rd_key);
				end
			end
			CMD_NEXT: begin
				if (cur_ok) begin
					rsp_d.entry_valid = 1'b1;
					rsp_d.entry_key   = KEY_IN_W'(rd_key);
				end
				cursor_d = (cur_inc >= cnt_s) ? (cnt_s - CUR_W'(1)) : cur_inc;
			end
			CMD_PREV: begin
				if (cur_ok) begin
					rsp_d.entry_valid = 1'b1;
					rsp_d.entry_key   = KEY_IN_W'(rd_key);
				end
				cursor_d = (cur_dec < 0) ? '0 : cur_dec;
			end
			CMD_RESET: begin
				cursor_d = '0;
			end
			default: begin
				cursor_d = cursor_q;
			end
		endcase
		rsp_d.entry_count = COUNT_O_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else if (ctl.execute) begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.execute) rsp_q <= rsp_d;
	end

	// shift towards the back up to the hit position, new key at the front
	always_ff @(posedge clk) begin
		if (ctl.execute && (cmd_q == CMD_ADD) && shift_q[0]) cell_q[0] <= key_q;
	end

	for (genvar g = 1; g < DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ctl.execute && (cmd_q == CMD_ADD) && shift_q[g]) cell_q[g] <= cell_q[g-1];
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: sv/mru_move_to_front_list.sv
// ----------------------------------------------------------------------------
// mru_move_to_front_list
// Most-recently-used key list with move-to-front on add, indexed read and
// a clamped browsing cursor.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                word
//  req      in         req_valid / req_stall    req_t  (cmd, key, index)
//  rsp      out        rsp_valid / rsp_stall    rsp_t  (entry_key, entry_valid,
//                                                       was_hit, entry_count)
//
// every command runs as a capture with the parallel key compare,
// then the cell shift or read and the result register load
// one command in flight; a new word is taken while the last result waits
// a stalled result holds the execute step until the result register frees
// arst_n empties the list and sets the cursor to zero; no clearing pass
// ----------------------------------------------------------------------------
module mru_move_to_front_list import mrul_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_t ctl;

	mrul_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	mrul_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
